### design/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg: shared types, widths and helpers for the point to disk distance
// Fixed point widths of every pipeline quantity, the configuration and the
// payload structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package pdd_pkg;

    localparam int COORD_W   = 32;
    localparam int AXIS_W    = 32;
    localparam int RAD_W     = 31;
    localparam int AXIS_FRAC = 30;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam int V_W     = COORD_W + 1;       // point minus center
    localparam int PROD_W  = AXIS_W + V_W;      // axis times offset
    localparam int DSUM_W  = PROD_W + 2;        // sum of three products
    localparam int D_W     = 34;                // saturated axial offset
    localparam int DM_W    = D_W - 1;           // magnitude of d
    localparam int AD_W    = AXIS_W + D_W;      // axis times d
    localparam int QX_W    = 37;                // q before truncation
    localparam int Q_W     = 35;                // planar offset
    localparam int M_W     = Q_W;               // magnitude of q
    localparam int SQ_W    = 2 * M_W;           // square of one component
    localparam int RADIC_W = 72;                // square root operand
    localparam int ROOT_W  = RADIC_W / 2;       // square root result
    localparam int DSQ_W   = 2 * DM_W;
    localparam int S_W     = AXIS_FRAC;         // radius scale quotient
    localparam int REM_W   = ROOT_W + 1;        // divider remainder
    localparam int OP_W    = M_W + S_W;         // offset times scale
    localparam int OFF_W   = M_W;               // scaled offset
    localparam int SUM_W   = 37;                // center plus offset

    localparam longint HALF_AXIS = 64'sd1 <<< (AXIS_FRAC - 1);
    localparam longint D_LIMIT   = (64'sd1 <<< (D_W - 1)) - 1;
    localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(64'sd1 <<< AXIS_FRAC);
    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_AXIS_X   = 3'd3,
        REG_AXIS_Y   = 3'd4,
        REG_AXIS_Z   = 3'd5,
        REG_RADIUS   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] center;
        logic [2:0][AXIS_W-1:0]  axis;
        logic [RAD_W-1:0]        radius;
    } cfg_t;

    typedef struct packed {
        logic signed [D_W-1:0] d;
        logic [2:0][Q_W-1:0]   q;
        logic [S_W-1:0]        s;
        logic                  in_disk;
    } side_t;

    typedef struct packed {
        logic               valid;
        logic [RADIC_W-1:0] rad;
        side_t              side;
    } sqi_t;

    typedef struct packed {
        logic              valid;
        logic [ROOT_W-1:0] root;
        side_t             side;
    } sqo_t;

    typedef struct packed {
        logic               valid;
        logic [RADIC_W-1:0] rad;
        logic [ROOT_W-1:0]  p;
        logic [REM_W-1:0]   rem;
        side_t              side;
    } dv_t;

    function automatic logic signed [AXIS_W-1:0] clamp_axis(input logic [AXIS_W-1:0] raw);
        logic signed [AXIS_W-1:0] v;
        v = $signed(raw);
        if (v > AXIS_ONE) begin
            v = AXIS_ONE;
        end else if (v < -AXIS_ONE) begin
            v = -AXIS_ONE;
        end
        return v;
    endfunction

    function automatic logic [31:0] sat_u32(input logic [ROOT_W-1:0] x);
        return (|x[ROOT_W-1:32]) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sh7FFF_FFFF);
        lo = SUM_W'(-64'sh8000_0000);
        if (x > hi) begin
            return 32'h7FFF_FFFF;
        end else if (x < lo) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

### design/point_to_disk_distance.sv
// pipeline: front, norm root, rim operand, divider, rim root and output sections,
// in that order from input transaction to result
// throughput: one point per cycle; each root and the divider resolve one bit
// per pipeline stage, and a stalled output freezes the whole pipeline
// reset: synchronous active low, empties the pipeline and loads the default
// disk (origin center, +z axis, radius 1.0)
// ----------------------------------------------------------------------------
// point_to_disk_distance: streaming point to 3d disk distance
// Query points in on the s_ stream, distances, closest point and inside flag
// out on the m_ stream; disk set through the register port.
// ----------------------------------------------------------------------------
module point_to_disk_distance import pdd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // stream in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,   // point_x, point_y, point_z
    // stream out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [159:0]      m_tdata,   // disk_distance, rim_distance,
                                         // closest_x, closest_y, closest_z
    output logic [0:0]        m_tuser,   // within_disk
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [2:0][COORD_W-1:0] center_reg;
    logic [2:0][AXIS_W-1:0]  axis_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic                    cfg_wr;
    reg_idx_t                idx;
    cfg_t                    cfg;
    logic                    adv;

    sqi_t             front_out;
    sqo_t             norm_out;
    dv_t              mid_out;
    sqi_t             div_out;
    sqo_t             rim_out;
    logic [31:0]      disk_dist;
    logic [31:0]      rim_dist;
    logic [2:0][31:0] closest;
    logic             in_disk;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg  <= '0;
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= AXIS_ONE;
            radius_reg  <= RADIUS_RESET;
        end else if (cfg_wr) begin
            case (idx)
                REG_CENTER_X: center_reg[0] <= pwdata;
                REG_CENTER_Y: center_reg[1] <= pwdata;
                REG_CENTER_Z: center_reg[2] <= pwdata;
                REG_AXIS_X:   axis_reg[0]   <= pwdata;
                REG_AXIS_Y:   axis_reg[1]   <= pwdata;
                REG_AXIS_Z:   axis_reg[2]   <= pwdata;
                REG_RADIUS:   radius_reg    <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CENTER_X: prdata = center_reg[0];
            REG_CENTER_Y: prdata = center_reg[1];
            REG_CENTER_Z: prdata = center_reg[2];
            REG_AXIS_X:   prdata = axis_reg[0];
            REG_AXIS_Y:   prdata = axis_reg[1];
            REG_AXIS_Z:   prdata = axis_reg[2];
            REG_RADIUS:   prdata = DATA_W'(radius_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.center = center_reg;
    assign cfg.axis   = axis_reg;
    assign cfg.radius = radius_reg;

    // the whole pipeline moves unless a result is held at the output
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    pdd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_tvalid),
        .point    (s_tdata),
        .cfg      (cfg),
        .out      (front_out)
    );

    pdd_sqrt u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in      (front_out),
        .out     (norm_out)
    );

    pdd_mid u_mid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in      (norm_out),
        .radius  (radius_reg),
        .out     (mid_out)
    );

    pdd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in      (mid_out),
        .out     (div_out)
    );

    pdd_sqrt u_rim (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in      (div_out),
        .out     (rim_out)
    );

    pdd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in            (rim_out),
        .center        (center_reg),
        .out_valid     (m_tvalid),
        .disk_distance (disk_dist),
        .rim_distance  (rim_dist),
        .closest       (closest),
        .within_disk   (in_disk)
    );

    assign m_tdata = {closest[2], closest[1], closest[0], rim_dist, disk_dist};
    assign m_tuser = in_disk;

endmodule

### design/pdd_front.sv
// ----------------------------------------------------------------------------
// pdd_front: offset, axial projection and planar norm operand
// Seven stages: center subtract, axis products, rounded dot product with
// clamp, axis times d, planar offset, component squares, sum of squares.
// ----------------------------------------------------------------------------
module pdd_front import pdd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][COORD_W-1:0] point,
    input  cfg_t                    cfg,
    output sqi_t                    out
);

    logic [6:0] vld_reg;

    logic signed [AXIS_W-1:0] a [3];
    logic signed [V_W-1:0]    v1_next [3];
    logic signed [V_W-1:0]    v1_reg [3];
    logic signed [PROD_W-1:0] prod2_next [3];
    logic signed [PROD_W-1:0] prod2_reg [3];
    logic signed [V_W-1:0]    v2_reg [3];
    logic signed [DSUM_W-1:0] dsum;
    logic signed [DSUM_W-1:0] dshift;
    logic signed [D_W-1:0]    d3_next;
    logic signed [D_W-1:0]    d3_reg;
    logic signed [V_W-1:0]    v3_reg [3];
    logic signed [AD_W-1:0]   ad4_next [3];
    logic signed [AD_W-1:0]   ad4_reg [3];
    logic signed [D_W-1:0]    d4_reg;
    logic signed [V_W-1:0]    v4_reg [3];
    logic signed [AD_W-1:0]   qr [3];
    logic signed [Q_W-1:0]    q5_next [3];
    logic signed [Q_W-1:0]    q5_reg [3];
    logic signed [D_W-1:0]    d5_reg;
    logic [M_W-1:0]           m [3];
    logic [SQ_W-1:0]          sq6_next [3];
    logic [SQ_W-1:0]          sq6_reg [3];
    logic signed [Q_W-1:0]    q6_reg [3];
    logic signed [D_W-1:0]    d6_reg;
    logic [RADIC_W-1:0]       rad7_next;
    logic [RADIC_W-1:0]       rad7_reg;
    logic signed [Q_W-1:0]    q7_reg [3];
    logic signed [D_W-1:0]    d7_reg;

    localparam logic signed [DSUM_W-1:0] D_HI = DSUM_W'(D_LIMIT);
    localparam logic signed [D_W-1:0]    D_MAX = D_W'(D_LIMIT);

    always_comb begin
        dsum = DSUM_W'(HALF_AXIS);
        for (int i = 0; i < 3; i++) begin
            a[i]          = clamp_axis(cfg.axis[i]);
            v1_next[i]    = V_W'($signed(point[i])) - V_W'($signed(cfg.center[i]));
            prod2_next[i] = PROD_W'(a[i]) * PROD_W'(v1_reg[i]);
            dsum          = dsum + DSUM_W'(prod2_reg[i]);
            ad4_next[i]   = AD_W'(a[i]) * AD_W'(d3_reg);
            qr[i]         = (ad4_reg[i] + AD_W'(HALF_AXIS)) >>> AXIS_FRAC;
            q5_next[i]    = Q_W'(QX_W'(v4_reg[i]) - QX_W'(qr[i]));
            m[i]          = q5_reg[i][Q_W-1] ? M_W'(-q5_reg[i]) : M_W'(q5_reg[i]);
            sq6_next[i]   = SQ_W'(m[i]) * SQ_W'(m[i]);
        end
        dshift = dsum >>> AXIS_FRAC;
        if (dshift > D_HI) begin
            d3_next = D_MAX;
        end else if (dshift < -D_HI) begin
            d3_next = -D_MAX;
        end else begin
            d3_next = D_W'(dshift);
        end
        rad7_next = RADIC_W'(sq6_reg[0]) + RADIC_W'(sq6_reg[1]) + RADIC_W'(sq6_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                v1_reg[i]    <= v1_next[i];
                prod2_reg[i] <= prod2_next[i];
                v2_reg[i]    <= v1_reg[i];
                v3_reg[i]    <= v2_reg[i];
                ad4_reg[i]   <= ad4_next[i];
                v4_reg[i]    <= v3_reg[i];
                q5_reg[i]    <= q5_next[i];
                sq6_reg[i]   <= sq6_next[i];
                q6_reg[i]    <= q5_reg[i];
                q7_reg[i]    <= q6_reg[i];
            end
            d3_reg   <= d3_next;
            d4_reg   <= d3_reg;
            d5_reg   <= d4_reg;
            d6_reg   <= d5_reg;
            d7_reg   <= d6_reg;
            rad7_reg <= rad7_next;
        end
    end

    always_comb begin
        out.valid        = vld_reg[6];
        out.rad          = rad7_reg;
        out.side.d       = d7_reg;
        out.side.s       = '0;
        out.side.in_disk = 1'b0;
        for (int i = 0; i < 3; i++) begin
            out.side.q[i] = q7_reg[i];
        end
    end

endmodule

### design/pdd_sqrt.sv
// ----------------------------------------------------------------------------
// pdd_sqrt: pipelined floor square root
// One result bit per stage, most significant first; the remainder holds the
// operand minus the square of the partial root.
// ----------------------------------------------------------------------------
module pdd_sqrt import pdd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  sqi_t in,
    output sqo_t out
);

    logic               vld_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];
    side_t              side_reg [ROOT_W];
    logic [RADIC_W-1:0] rem_reg  [ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;

        logic               vld_at;
        logic [ROOT_W-1:0]  root_at;
        side_t              side_at;
        logic [RADIC_W-1:0] rem_at;
        logic [RADIC_W-1:0] trial;
        logic               take;

        if (k == 0) begin : g_first
            assign vld_at  = in.valid;
            assign root_at = '0;
            assign side_at = in.side;
            assign rem_at  = in.rad;
        end else begin : g_next
            assign vld_at  = vld_reg[k-1];
            assign root_at = root_reg[k-1];
            assign side_at = side_reg[k-1];
            assign rem_at  = rem_reg[k-1];
        end

        assign trial = (RADIC_W'(root_at) << (B + 1)) | (RADIC_W'(1) << (2 * B));
        assign take  = trial <= rem_at;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_at;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= take ? (root_at | (ROOT_W'(1) << B)) : root_at;
                side_reg[k] <= side_at;
            end
        end

        if (k < ROOT_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? rem_at - trial : rem_at;
                end
            end
        end
    end

    assign out.valid = vld_reg[ROOT_W-1];
    assign out.root  = root_reg[ROOT_W-1];
    assign out.side  = side_reg[ROOT_W-1];

endmodule

### design/pdd_mid.sv
// ----------------------------------------------------------------------------
// pdd_mid: inside test and rim distance operand
// Three stages: compare with the radius, square d and the radial gap, sum
// the squares; also seeds the radius divider.
// ----------------------------------------------------------------------------
module pdd_mid import pdd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  sqo_t             in,
    input  logic [RAD_W-1:0] radius,
    output dv_t              out
);

    logic [2:0] vld_reg;

    logic [ROOT_W-1:0]  rad_ext;
    logic               in_disk;
    side_t              side_next;
    logic [ROOT_W-1:0]  diff_next;
    logic [DM_W-1:0]    dmag_next;

    logic [ROOT_W-1:0]  pa_reg, pb_reg, pc_reg;
    side_t              sa_reg, sb_reg, sc_reg;
    logic [ROOT_W-1:0]  diff_reg;
    logic [DM_W-1:0]    dmag_reg;
    logic [DSQ_W-1:0]   dsq_reg;
    logic [RADIC_W-1:0] dfsq_reg;
    logic [RADIC_W-1:0] rad_reg;

    always_comb begin
        rad_ext   = ROOT_W'(radius);
        in_disk   = in.root <= rad_ext;
        diff_next = in_disk ? rad_ext - in.root : in.root - rad_ext;
        dmag_next = in.side.d[D_W-1] ? DM_W'(-in.side.d) : DM_W'(in.side.d);
        side_next = in.side;
        side_next.in_disk = in_disk;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg   <= in.root;
            sa_reg   <= side_next;
            diff_reg <= diff_next;
            dmag_reg <= dmag_next;
            pb_reg   <= pa_reg;
            sb_reg   <= sa_reg;
            dsq_reg  <= DSQ_W'(dmag_reg) * DSQ_W'(dmag_reg);
            dfsq_reg <= RADIC_W'(diff_reg) * RADIC_W'(diff_reg);
            pc_reg   <= pb_reg;
            sc_reg   <= sb_reg;
            rad_reg  <= RADIC_W'(dsq_reg) + dfsq_reg;
        end
    end

    // remainder starts at the radius, quotient is radius * 2^30 / p
    assign out.valid = vld_reg[2];
    assign out.rad   = rad_reg;
    assign out.p     = pc_reg;
    assign out.rem   = REM_W'(radius);
    assign out.side  = sc_reg;

endmodule

### design/pdd_div.sv
// ----------------------------------------------------------------------------
// pdd_div: pipelined radius scale divider
// Restoring long division, one quotient bit per stage; only meaningful when
// the planar norm exceeds the radius.
// ----------------------------------------------------------------------------
module pdd_div import pdd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  dv_t  in,
    output sqi_t out
);

    logic               vld_reg  [S_W];
    logic [RADIC_W-1:0] rad_reg  [S_W];
    logic [ROOT_W-1:0]  p_reg    [S_W-1];
    logic [REM_W-1:0]   rem_reg  [S_W-1];
    side_t              side_reg [S_W];

    for (genvar k = 0; k < S_W; k++) begin : g_stage
        localparam int B = S_W - 1 - k;

        logic               vld_at;
        logic [RADIC_W-1:0] rad_at;
        logic [ROOT_W-1:0]  p_at;
        logic [REM_W-1:0]   rem_at;
        side_t              side_at;
        logic [REM_W-1:0]   rem2;
        logic               ge;
        side_t              side_nx;

        if (k == 0) begin : g_first
            assign vld_at  = in.valid;
            assign rad_at  = in.rad;
            assign p_at    = in.p;
            assign rem_at  = in.rem;
            assign side_at = in.side;
        end else begin : g_next
            assign vld_at  = vld_reg[k-1];
            assign rad_at  = rad_reg[k-1];
            assign p_at    = p_reg[k-1];
            assign rem_at  = rem_reg[k-1];
            assign side_at = side_reg[k-1];
        end

        always_comb begin
            rem2       = {rem_at[REM_W-2:0], 1'b0};
            ge         = rem2 >= REM_W'(p_at);
            side_nx    = side_at;
            side_nx.s[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_at;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_at;
                side_reg[k] <= side_nx;
            end
        end

        if (k < S_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    p_reg[k]   <= p_at;
                    rem_reg[k] <= ge ? rem2 - REM_W'(p_at) : rem2;
                end
            end
        end
    end

    assign out.valid = vld_reg[S_W-1];
    assign out.rad   = rad_reg[S_W-1];
    assign out.side  = side_reg[S_W-1];

endmodule

### design/pdd_back.sv
// ----------------------------------------------------------------------------
// pdd_back: closest point and output register
// Scales the planar offset to the rim, picks inside or rim results and
// saturates everything into the output register.
// ----------------------------------------------------------------------------
module pdd_back import pdd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  sqo_t                    in,
    input  logic [2:0][COORD_W-1:0] center,
    output logic                    out_valid,
    output logic [31:0]             disk_distance,
    output logic [31:0]             rim_distance,
    output logic [2:0][31:0]        closest,
    output logic                    within_disk
);

    logic              vld1_reg;
    logic [OP_W-1:0]   oprod_next [3];
    logic [OP_W-1:0]   oprod_reg [3];
    logic [ROOT_W-1:0] rim_reg;
    side_t             side_reg;

    logic [OFF_W-1:0]        off [3];
    logic signed [SUM_W-1:0] so [3];
    logic signed [SUM_W-1:0] csum [3];
    logic [DM_W-1:0]         dmag;
    logic [31:0]             disk_next;
    logic [2:0][31:0]        closest_next;

    logic             out_vld_reg;
    logic [31:0]      disk_reg;
    logic [31:0]      rim_out_reg;
    logic [2:0][31:0] closest_reg;
    logic             in_disk_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            oprod_next[i] = in.side.q[i][Q_W-1]
                          ? OP_W'(M_W'(-$signed(in.side.q[i]))) * OP_W'(in.side.s)
                          : OP_W'(in.side.q[i]) * OP_W'(in.side.s);
        end
    end

    always_comb begin
        dmag = side_reg.d[D_W-1] ? DM_W'(-side_reg.d) : DM_W'(side_reg.d);
        disk_next = side_reg.in_disk ? sat_u32(ROOT_W'(dmag)) : sat_u32(rim_reg);
        for (int i = 0; i < 3; i++) begin
            off[i] = OFF_W'((oprod_reg[i] + OP_W'(HALF_AXIS)) >> AXIS_FRAC);
            so[i]  = $signed(SUM_W'(off[i]));
            if (side_reg.q[i][Q_W-1]) begin
                so[i] = -so[i];
            end
            if (side_reg.in_disk) begin
                csum[i] = SUM_W'($signed(center[i])) + SUM_W'($signed(side_reg.q[i]));
            end else begin
                csum[i] = SUM_W'($signed(center[i])) + so[i];
            end
            closest_next[i] = sat_s32(csum[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld1_reg    <= in.valid;
            out_vld_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                oprod_reg[i] <= oprod_next[i];
            end
            rim_reg     <= in.root;
            side_reg    <= in.side;
            disk_reg    <= disk_next;
            rim_out_reg <= sat_u32(rim_reg);
            closest_reg <= closest_next;
            in_disk_reg <= side_reg.in_disk;
        end
    end

    assign out_valid     = out_vld_reg;
    assign disk_distance = disk_reg;
    assign rim_distance  = rim_out_reg;
    assign closest       = closest_reg;
    assign within_disk   = in_disk_reg;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for point_to_disk_distance
// Streams query points through the block under several disk settings and
// idle patterns. A scoreboard predicts the distances, the closest point and
// the inside flag of every point and checks each result transaction in order.
// ----------------------------------------------------------------------------

class disk_scoreboard;
    typedef struct {
        logic [31:0] disk_dist;
        logic [31:0] rim_dist;
        logic [31:0] closest[3];
        logic        in_disk;
    } disk_result_t;

    logic signed [31:0] center[3];
    logic signed [31:0] axis[3];
    logic [30:0]        radius;
    disk_result_t       pending_results[$];
    int                 errors;
    int                 checked;
    int                 inside_seen;

    function new();
        center = '{0, 0, 0};
        axis = '{0, 0, 32'sh4000_0000};
        radius = 31'd65536;
        errors = 0;
        checked = 0;
        inside_seen = 0;
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 37; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mag(logic signed [79:0] x);
        logic [79:0] m;
        m = (x < 0) ? -x : x;
        return {48'd0, m};
    endfunction

    function automatic logic [31:0] sat_signed(logic signed [79:0] x);
        if (x > 80'sh7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (x < -80'sh8000_0000) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic [31:0] sat_unsigned(logic [127:0] x);
        return (x > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function void note_point(logic [95:0] pt);
        logic signed [79:0] c[3];
        logic signed [79:0] a[3];
        logic signed [79:0] v[3];
        logic signed [79:0] q[3];
        logic signed [79:0] dsum;
        logic signed [79:0] d;
        logic signed [79:0] so;
        logic signed [79:0] half;
        logic signed [79:0] dlim;
        logic signed [31:0] pc;
        logic [127:0] acc;
        logic [127:0] p;
        logic [127:0] rad;
        logic [127:0] diff;
        logic [127:0] dm;
        logic [127:0] s;
        logic [127:0] off;
        disk_result_t r;
        half = 80'sd1 <<< 29;
        dlim = (80'sd1 <<< 33) - 1;
        dsum = 0;
        for (int i = 0; i < 3; i++) begin
            pc = pt[32*i +: 32];
            c[i] = center[i];
            a[i] = axis[i];
            if (a[i] > (80'sd1 <<< 30)) a[i] = 80'sd1 <<< 30;
            if (a[i] < -(80'sd1 <<< 30)) a[i] = -(80'sd1 <<< 30);
            v[i] = pc;
            v[i] = v[i] - c[i];
            dsum = dsum + a[i] * v[i];
        end
        d = (dsum + half) >>> 30;
        if (d > dlim) d = dlim;
        if (d < -dlim) d = -dlim;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            q[i] = v[i] - ((a[i] * d + half) >>> 30);
            acc = acc + mag(q[i]) * mag(q[i]);
        end
        p = isqrt(acc);
        rad = {97'd0, radius};
        diff = (p >= rad) ? p - rad : rad - p;
        dm = mag(d);
        r.rim_dist = sat_unsigned(isqrt(dm * dm + diff * diff));
        if (p <= rad) begin
            r.disk_dist = sat_unsigned(dm);
            for (int i = 0; i < 3; i++) r.closest[i] = sat_signed(c[i] + q[i]);
            r.in_disk = 1'b1;
        end else begin
            r.disk_dist = r.rim_dist;
            s = (rad << 30) / p;
            for (int i = 0; i < 3; i++) begin
                off = (mag(q[i]) * s + 128'd536870912) >> 30;
                so = $signed({1'b0, off[78:0]});
                if (q[i] < 0) so = -so;
                r.closest[i] = sat_signed(c[i] + so);
            end
            r.in_disk = 1'b0;
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [159:0] data, logic in_disk);
        disk_result_t e;
        logic [31:0] got[5];
        logic [31:0] exp_f[5];
        for (int i = 0; i < 5; i++) got[i] = data[32*i +: 32];
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: %h %b", $time, data, in_disk);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        checked++;
        if (e.in_disk) inside_seen++;
        exp_f = '{e.disk_dist, e.rim_dist, e.closest[0], e.closest[1], e.closest[2]};
        for (int i = 0; i < 5; i++) begin
            if (got[i] !== exp_f[i]) begin
                $display("%0t: field %0d mismatch: expected %h, actual %h",
                         $time, i, exp_f[i], got[i]);
                errors++;
            end
        end
        if (in_disk !== e.in_disk) begin
            $display("%0t: within_disk mismatch: expected %b, actual %b",
                     $time, e.in_disk, in_disk);
            errors++;
        end
    endfunction
endclass

module tb;
    import pdd_pkg::*;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic         pready;

    disk_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int points_sent = 0;

    point_to_disk_distance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

    // transaction monitors on both streams
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_point(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CENTER_X: sb.center[0] = val;
            REG_CENTER_Y: sb.center[1] = val;
            REG_CENTER_Z: sb.center[2] = val;
            REG_AXIS_X:   sb.axis[0] = val;
            REG_AXIS_Y:   sb.axis[1] = val;
            REG_AXIS_Z:   sb.axis[2] = val;
            default:      sb.radius = val[30:0];
        endcase
    endtask

    task automatic set_disk(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                            logic [31:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_AXIS_X, ax);
        write_reg(REG_AXIS_Y, ay);
        write_reg(REG_AXIS_Z, az);
        write_reg(REG_RADIUS, rad);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        points_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // coordinate near the center so that inside cases are common
    function automatic logic [31:0] near(logic [31:0] c, int span);
        return c + 32'($urandom_range(2 * span) - span);
    endfunction

    function automatic logic [31:0] rand_axis();
        if ($urandom_range(9) == 0) return $urandom();
        return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    task automatic random_points(int n);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        int span;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(2) == 0) begin
                x = $urandom();
                y = $urandom();
                z = $urandom();
            end else begin
                span = 1 << $urandom_range(26, 4);
                x = near(sb.center[0], span);
                y = near(sb.center[1], span);
                z = near(sb.center[2], span);
            end
            send_point(x, y, z);
            if (k == n / 2 && send_idle_pct == 0 && recv_stall_pct == 0) begin
                s_tvalid <= 1'b0;
                while (sb.pending_results.size() != 0) @(posedge aclk);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset disk: unit disk in the xy plane
        send_point(0, 0, 0);
        send_point(32'h0001_0000, 0, 32'h0005_0000);
        send_point(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        drain();

        // zero radius, axis out of range and clamped, extreme center
        set_disk(32'h7FFF_FFFF, 32'h8000_0000, 0,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_point(0, 0, 32'h8000_0000);
        send_point(32'h7FFF_0000, 32'h8001_0000, 32'h0001_0000);
        drain();

        // largest radius, tilted axis that is not unit length
        set_disk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hC000_0000, 32'h4000_0000, 32'h4000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(0, 0, 0);
        send_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_AAAA);
        drain();

        // unit x axis, moderate radius, points on and off the axis
        set_disk(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000,
                 32'h4000_0000, 0, 0, 32'h0008_0000);
        send_point(32'h0020_0000, 32'hFFF0_0000, 32'h0000_8000);
        send_point(32'h0010_0000, 32'hFFF8_0000, 32'h0000_8000);
        send_point(32'h0010_0000, 32'h0000_0000, 32'h0000_8000);
        send_point(32'h0000_0000, 32'hFFE0_0000, 32'h0020_0000);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 25; recv_stall_pct = 25; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            set_disk($urandom(), $urandom(), $urandom(), rand_axis(), rand_axis(),
                     rand_axis(), 32'($urandom_range(32'h7FFF_FFFF) >> $urandom_range(30)));
            random_points(90);
            drain();
            set_disk(near(0, 1 << 20), near(0, 1 << 20), near(0, 1 << 20),
                     rand_axis(), rand_axis(), rand_axis(),
                     32'($urandom_range(1 << 22)));
            random_points(90);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        $display("%0d points sent over several disk settings and idle patterns", points_sent);
        $display("%0d results checked, %0d inside the disk, %0d errors",
                 sb.checked, sb.inside_seen, sb.errors);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
